>>> hdl/modbus_tcp_write_request_framer_unit_assert.svh
// Assertion macros for the Modbus TCP write request framer.
`ifndef MODBUS_TCP_WRITE_REQUEST_FRAMER_UNIT_ASSERT_SVH
`define MODBUS_TCP_WRITE_REQUEST_FRAMER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Checks that ante implies cons in the same cycle.
`define MTWF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Checks that ante implies cons in the next cycle.
`define MTWF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MTWF_ASSERT_NOW(lbl, ante, cons, msg)
`define MTWF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/mtwf_pkg.sv
// Types and constants shared by the Modbus TCP write request framer.
package mtwf_pkg;

    localparam logic [1:0] CFG_UNIT_ADDRESS  = 2'd0;
    localparam logic [1:0] CFG_FIRST_ADDRESS = 2'd1;
    localparam logic [1:0] CFG_COIL_MODE     = 2'd2;
    localparam logic [1:0] CFG_VALUE_COUNT   = 2'd3;

    localparam logic [7:0]  FC_WRITE_COILS = 8'h0F;
    localparam logic [7:0]  FC_WRITE_REGS  = 8'h10;
    localparam logic [15:0] TRANSACTION_ID = 16'h0001;
    localparam logic [15:0] PROTOCOL_ID    = 16'h0000;
    localparam logic [8:0]  MBAP_LEN_BASE  = 9'd7;
    localparam logic [3:0]  HEADER_BYTES   = 4'd13;

    typedef struct packed {
        logic [7:0]  unit_address;
        logic [15:0] first_address;
        logic        coil_mode;
        logic [6:0]  value_count;
    } t_cfg;

    // One queued job: an optional header followed by zero to two data bytes.
    typedef struct packed {
        logic        hdr;
        logic        coil_mode;
        logic [7:0]  unit_address;
        logic [15:0] first_address;
        logic [6:0]  count;
        logic [7:0]  data_bytes;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [1:0]  ndata;
        logic        last;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_status;

endpackage

>>> hdl/mtwf_in_if.sv
// Input channel: one value word per handshake.
interface mtwf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

>>> hdl/mtwf_out_if.sv
// Output channel: one frame byte word per handshake.
interface mtwf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink (input valid, input frame_byte, input frame_end, output ready);
endinterface

>>> hdl/mtwf_front.sv
// Front end: accepts values, tracks the request position and builds queue entries.
module mtwf_front #(
    parameter int MAX_VALUES = 123
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mtwf_pkg::t_cfg   i_cfg,
    input  logic             i_accept,
    input  logic [15:0]      i_value,
    output logic             o_push,
    output mtwf_pkg::t_entry o_entry
);
    import mtwf_pkg::*;

    localparam logic [6:0] MAX_COUNT = 7'(MAX_VALUES);

    logic [6:0] r_pos, n_pos;
    logic [7:0] r_coil_bits, n_coil_bits;
    logic [6:0] w_count;
    logic [7:0] w_data_bytes;
    logic [2:0] w_bit;
    logic [7:0] w_bits_set;
    logic       w_last;
    logic       w_coil_emit;
    logic       w_hdr;

    always_comb begin
        priority if (i_cfg.value_count == 7'd0) begin
            w_count = 7'd1;
        end else if (i_cfg.value_count > MAX_COUNT) begin
            w_count = MAX_COUNT;
        end else begin
            w_count = i_cfg.value_count;
        end
    end

    assign w_data_bytes = i_cfg.coil_mode ? 8'((8'(w_count) + 8'd7) >> 3)
                                          : {w_count, 1'b0};
    assign w_last      = (8'(r_pos) + 8'd1) >= 8'(w_count);
    assign w_hdr       = (r_pos == 7'd0);
    assign w_bit       = r_pos[2:0];
    assign w_bits_set  = r_coil_bits | ((i_value != 16'd0) ? (8'd1 << w_bit) : 8'd0);
    assign w_coil_emit = (w_bit == 3'd7) || w_last;

    always_comb begin
        o_entry.hdr           = w_hdr;
        o_entry.coil_mode     = i_cfg.coil_mode;
        o_entry.unit_address  = i_cfg.unit_address;
        o_entry.first_address = i_cfg.first_address;
        o_entry.count         = w_count;
        o_entry.data_bytes    = w_data_bytes;
        o_entry.b0            = i_cfg.coil_mode ? w_bits_set : i_value[15:8];
        o_entry.b1            = i_value[7:0];
        o_entry.last          = w_last;
        if (!i_cfg.coil_mode) begin
            o_entry.ndata = 2'd2;
        end else if (w_coil_emit) begin
            o_entry.ndata = 2'd1;
        end else begin
            o_entry.ndata = 2'd0;
        end
    end

    // A coil value that completes no byte and carries no header is dropped here.
    assign o_push = i_accept && (w_hdr || (o_entry.ndata != 2'd0));

    always_comb begin
        n_pos       = r_pos;
        n_coil_bits = r_coil_bits;
        if (i_accept) begin
            n_pos = w_last ? 7'd0 : r_pos + 7'd1;
            if (w_last || !i_cfg.coil_mode || w_coil_emit) begin
                n_coil_bits = 8'd0;
            end else begin
                n_coil_bits = w_bits_set;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 7'd0;
            r_coil_bits <= 8'd0;
        end else begin
            r_pos       <= n_pos;
            r_coil_bits <= n_coil_bits;
        end
    end
endmodule

>>> hdl/mtwf_fifo.sv
// Two-entry queue between the front end and the byte emitter.
module mtwf_fifo (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  mtwf_pkg::t_entry       i_entry,
    input  logic                   i_pop,
    output mtwf_pkg::t_entry       o_head,
    output mtwf_pkg::t_fifo_status o_status
);
    import mtwf_pkg::*;

    t_entry     r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_head         = r_mem[r_rp];
    assign o_status.full  = (r_cnt == 2'd2);
    assign o_status.empty = (r_cnt == 2'd0);

    always_comb begin
        n_wp  = i_push ? ~r_wp : r_wp;
        n_rp  = i_pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end
endmodule

>>> hdl/mtwf_back.sv
// Back end: walks the head entry into the output register one byte per cycle while the receiver takes bytes.
module mtwf_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mtwf_pkg::t_entry i_head,
    input  logic             i_head_valid,
    output logic             o_pop,
    mtwf_out_if.source       o_frame
);
    import mtwf_pkg::*;

    logic [3:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_byte, n_byte;
    logic       r_end, n_end;
    logic [3:0] w_abs;
    logic [3:0] w_final;
    logic [8:0] w_len;
    logic [7:0] w_sel;
    logic       w_load;

    // Entries without a header start at the first data byte position.
    assign w_abs   = r_idx + (i_head.hdr ? 4'd0 : HEADER_BYTES);
    assign w_final = HEADER_BYTES - 4'd1 + 4'(i_head.ndata);
    assign w_len   = MBAP_LEN_BASE + 9'(i_head.data_bytes);
    assign w_load  = i_head_valid && (!r_valid || o_frame.ready);
    assign o_pop   = w_load && (w_abs == w_final);

    always_comb begin
        unique case (w_abs)
            4'd0:    w_sel = TRANSACTION_ID[15:8];
            4'd1:    w_sel = TRANSACTION_ID[7:0];
            4'd2:    w_sel = PROTOCOL_ID[15:8];
            4'd3:    w_sel = PROTOCOL_ID[7:0];
            4'd4:    w_sel = 8'(w_len >> 8);
            4'd5:    w_sel = w_len[7:0];
            4'd6:    w_sel = i_head.unit_address;
            4'd7:    w_sel = i_head.coil_mode ? FC_WRITE_COILS : FC_WRITE_REGS;
            4'd8:    w_sel = i_head.first_address[15:8];
            4'd9:    w_sel = i_head.first_address[7:0];
            4'd10:   w_sel = 8'd0;
            4'd11:   w_sel = {1'b0, i_head.count};
            4'd12:   w_sel = i_head.data_bytes;
            4'd13:   w_sel = i_head.b0;
            4'd14:   w_sel = i_head.b1;
            default: w_sel = 8'd0;
        endcase
    end

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_end   = r_end;
        if (o_frame.ready) begin
            n_valid = 1'b0;
        end
        if (w_load) begin
            n_valid = 1'b1;
            n_byte  = w_sel;
            n_end   = o_pop && i_head.last && (i_head.ndata != 2'd0);
            n_idx   = o_pop ? 4'd0 : r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_end  <= n_end;
    end

    assign o_frame.valid      = r_valid;
    assign o_frame.frame_byte = r_byte;
    assign o_frame.frame_end  = r_end;
endmodule

>>> hdl/modbus_tcp_write_request_framer_unit.sv
// Top level of the Modbus TCP write multiple coils / registers request framer.
//
// Values enter on i_value_if, one 16-bit word per handshake; request bytes leave
// on o_frame_if, one byte per word, with frame_end set on the last byte.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data, index 0
// unit address, 1 first address, 2 coil mode, 3 count; the user must write it
// only while the block is idle, which the block itself does not enforce.
// The first value of a request produces the 13-byte MBAP and PDU header before
// its data. A register value gives two bytes; a coil value gives one byte after
// every eighth value or after the last one, and otherwise nothing.
// With the queue empty, an accepted value is written into the queue and its
// first byte then passes to the output register. The output emits one byte per
// cycle while the receiver is ready; the header adds 13 bytes at request start.
// A two-entry queue parts the value intake from the byte emitter, so values
// keep coming in while bytes of earlier ones are still going out.
// When the receiver stalls, the output register holds its byte, the queue
// fills and then the input ready drops. Reset clears the queue, the request
// position and gathered coil bits, and restores the configuration defaults.
module modbus_tcp_write_request_framer_unit #(
    parameter int MAX_VALUES = 123
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    mtwf_in_if.sink     i_value_if,
    mtwf_out_if.source  o_frame_if
);
    import mtwf_pkg::*;

    `include "modbus_tcp_write_request_framer_unit_assert.svh"

    t_cfg         r_cfg, n_cfg;
    t_entry       w_entry;
    t_entry       w_head;
    t_fifo_status w_fifo_status;
    logic         w_accept;
    logic         w_push;
    logic         w_pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_UNIT_ADDRESS:  n_cfg.unit_address  = i_cfg_data[7:0];
                CFG_FIRST_ADDRESS: n_cfg.first_address = i_cfg_data;
                CFG_COIL_MODE:     n_cfg.coil_mode     = i_cfg_data[0];
                CFG_VALUE_COUNT:   n_cfg.value_count   = i_cfg_data[6:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_address  <= 8'd1;
            r_cfg.first_address <= 16'd0;
            r_cfg.coil_mode     <= 1'b0;
            r_cfg.value_count   <= 7'd1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign i_value_if.ready = !w_fifo_status.full;
    assign w_accept         = i_value_if.valid && !w_fifo_status.full;

    mtwf_front #(
        .MAX_VALUES (MAX_VALUES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_accept(w_accept),
        .i_value (i_value_if.value),
        .o_push  (w_push),
        .o_entry (w_entry)
    );

    mtwf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_status(w_fifo_status)
    );

    mtwf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_head_valid(!w_fifo_status.empty),
        .o_pop       (w_pop),
        .o_frame     (o_frame_if)
    );

    `MTWF_ASSERT_NOW(a_no_overflow, w_push, !w_fifo_status.full, "queue push while full")
    `MTWF_ASSERT_NOW(a_no_underflow, w_pop, !w_fifo_status.empty, "queue pop while empty")
    `MTWF_ASSERT_NOW(a_header_queued, w_accept && w_entry.hdr, w_push, "request start not queued")
    `MTWF_ASSERT_NEXT(a_pop_shows_byte, w_pop, o_frame_if.valid, "popped entry left no byte")
endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Modbus TCP write multiple coils / registers request framer.
module tb_top;
    import mtwf_pkg::*;

    localparam int MAX_VALUES    = 123;
    localparam int RANDOM_ITEMS  = 100;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES  = 20;

    typedef enum logic {ROW_CFG, ROW_VALUE} t_row_kind;
    typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_BURSTY} t_rx_mode;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic [15:0] data;
        logic        typed;
        logic [7:0]  exp_hi;
        logic [7:0]  exp_lo;
    } t_row;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_frame_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    mtwf_in_if  value_ch ();
    mtwf_out_if frame_ch ();

    modbus_tcp_write_request_framer_unit #(
        .MAX_VALUES(MAX_VALUES)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_value_if(value_ch),
        .o_frame_if(frame_ch)
    );

    // Shadow of the block: configuration, request position and gathered coil bits.
    t_cfg        cfg;
    logic [6:0]  req_pos;
    logic [7:0]  coil_acc;
    t_frame_word frame_expect[$];
    bit          fail_seen;
    int          burst_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int active_count();
        if (cfg.value_count == 7'd0) begin
            return 1;
        end
        if (int'(cfg.value_count) > MAX_VALUES) begin
            return MAX_VALUES;
        end
        return int'(cfg.value_count);
    endfunction

    function automatic void push_word(input logic [7:0] b, input logic is_end);
        t_frame_word w;
        w.frame_byte = b;
        w.frame_end  = is_end;
        frame_expect.push_back(w);
    endfunction

    // Works out the bytes that one accepted value word causes.
    function automatic void frame_value(input logic [15:0] v);
        int   count;
        int   nbytes;
        int   len;
        int   bit_idx;
        logic last;
        count = active_count();
        last  = (int'(req_pos) + 1 >= count);
        if (req_pos == 7'd0) begin
            nbytes = cfg.coil_mode ? (count + 7) / 8 : count * 2;
            len    = int'(MBAP_LEN_BASE) + nbytes;
            push_word(TRANSACTION_ID[15:8], 1'b0);
            push_word(TRANSACTION_ID[7:0], 1'b0);
            push_word(PROTOCOL_ID[15:8], 1'b0);
            push_word(PROTOCOL_ID[7:0], 1'b0);
            push_word(8'(len >> 8), 1'b0);
            push_word(8'(len), 1'b0);
            push_word(cfg.unit_address, 1'b0);
            push_word(cfg.coil_mode ? FC_WRITE_COILS : FC_WRITE_REGS, 1'b0);
            push_word(cfg.first_address[15:8], 1'b0);
            push_word(cfg.first_address[7:0], 1'b0);
            push_word(8'(count >> 8), 1'b0);
            push_word(8'(count), 1'b0);
            push_word(8'(nbytes), 1'b0);
        end
        if (cfg.coil_mode) begin
            bit_idx = int'(req_pos[2:0]);
            if (v != 16'd0) begin
                coil_acc[bit_idx] = 1'b1;
            end
            if (bit_idx == 7 || last) begin
                push_word(coil_acc, last);
                coil_acc = 8'd0;
            end
        end else begin
            coil_acc = 8'd0;
            push_word(v[15:8], 1'b0);
            push_word(v[7:0], last);
        end
        if (last) begin
            req_pos  = 7'd0;
            coil_acc = 8'd0;
        end else begin
            req_pos = req_pos + 7'd1;
        end
    endfunction

    // Registers change only while nothing is in flight, so the intake is stopped first.
    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        value_ch.valid <= 1'b0;
        burst_left = 0;
        while (frame_expect.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_UNIT_ADDRESS:  cfg.unit_address  = data[7:0];
            CFG_FIRST_ADDRESS: cfg.first_address = data;
            CFG_COIL_MODE:     cfg.coil_mode     = data[0];
            CFG_VALUE_COUNT:   cfg.value_count   = data[6:0];
            default: ;
        endcase
    endtask

    // Offers one value word in bursts; valid stays high across words of a burst.
    task automatic send_value(input logic [15:0] v, input logic typed,
                              input logic [7:0] exp_hi, input logic [7:0] exp_lo);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                value_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        @(posedge i_clk);
        while (!value_ch.ready) @(posedge i_clk);
        frame_value(v);
        if (typed) begin
            frame_expect[frame_expect.size() - 2].frame_byte = exp_hi;
            frame_expect[frame_expect.size() - 1].frame_byte = exp_lo;
        end
        burst_left--;
        @(negedge i_clk);
    endtask

    function automatic t_row cfg_row(input logic [1:0] idx, input logic [15:0] data);
        return '{ROW_CFG, idx, data, 1'b0, 8'd0, 8'd0};
    endfunction

    function automatic t_row val_row(input logic [15:0] v);
        return '{ROW_VALUE, CFG_UNIT_ADDRESS, v, 1'b0, 8'd0, 8'd0};
    endfunction

    function automatic t_row chk_row(input logic [15:0] v, input logic [7:0] hi,
                                     input logic [7:0] lo);
        return '{ROW_VALUE, CFG_UNIT_ADDRESS, v, 1'b1, hi, lo};
    endfunction

    // Receiver: ready follows a mode that is chosen anew at random when the current one runs out.
    initial begin
        t_rx_mode    rx_mode;
        int unsigned mode_left;
        int unsigned stall_left;
        mode_left      = 0;
        stall_left     = 0;
        frame_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (rx_mode)
                RX_FREE: frame_ch.ready <= 1'b1;
                RX_COIN: frame_ch.ready <= 1'($urandom_range(0, 1));
                default: begin
                    if (stall_left != 0) begin
                        stall_left--;
                        frame_ch.ready <= 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        stall_left = $urandom_range(4, 16);
                        frame_ch.ready <= 1'b0;
                    end else begin
                        frame_ch.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_frame_word w;
        if (i_rst_n && frame_ch.valid && frame_ch.ready) begin
            if (frame_expect.size() == 0) begin
                $error("unexpected word: frame_byte %h frame_end %b",
                       frame_ch.frame_byte, frame_ch.frame_end);
                fail_seen = 1'b1;
            end else begin
                w = frame_expect.pop_front();
                if (frame_ch.frame_byte !== w.frame_byte) begin
                    $error("frame_byte: expected %h, actual %h", w.frame_byte,
                           frame_ch.frame_byte);
                    fail_seen = 1'b1;
                end
                if (frame_ch.frame_end !== w.frame_end) begin
                    $error("frame_end: expected %b, actual %b", w.frame_end,
                           frame_ch.frame_end);
                    fail_seen = 1'b1;
                end
            end
        end
    end

    initial begin
        t_row        stim_table[$];
        int          random_sent;
        int          nvals;
        logic [15:0] v;
        fail_seen         = 1'b0;
        burst_left        = 0;
        req_pos           = 7'd0;
        coil_acc          = 8'd0;
        cfg.unit_address  = 8'd1;
        cfg.first_address = 16'd0;
        cfg.coil_mode     = 1'b0;
        cfg.value_count   = 7'd1;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = CFG_UNIT_ADDRESS;
        i_cfg_data        = 16'd0;
        value_ch.valid    = 1'b0;
        value_ch.value    = 16'd0;

        // Register mode out of reset, then extreme header fields.
        stim_table.push_back(chk_row(16'hFFFF, 8'hFF, 8'hFF));
        stim_table.push_back(chk_row(16'h0000, 8'h00, 8'h00));
        stim_table.push_back(cfg_row(CFG_UNIT_ADDRESS, 16'h00FF));
        stim_table.push_back(cfg_row(CFG_FIRST_ADDRESS, 16'hFFFF));
        stim_table.push_back(cfg_row(CFG_VALUE_COUNT, 16'd2));
        stim_table.push_back(chk_row(16'h8001, 8'h80, 8'h01));
        stim_table.push_back(chk_row(16'h7FFE, 8'h7F, 8'hFE));
        // Coil mode with a zero count, which acts as one; only a high bit is set.
        stim_table.push_back(cfg_row(CFG_COIL_MODE, 16'd1));
        stim_table.push_back(cfg_row(CFG_UNIT_ADDRESS, 16'h0000));
        stim_table.push_back(cfg_row(CFG_FIRST_ADDRESS, 16'h0000));
        stim_table.push_back(cfg_row(CFG_VALUE_COUNT, 16'd0));
        stim_table.push_back(val_row(16'h0100));
        // Nine coils: one full byte, then a lone bit that closes the request.
        stim_table.push_back(cfg_row(CFG_VALUE_COUNT, 16'd9));
        stim_table.push_back(val_row(16'h0001));
        stim_table.push_back(val_row(16'h0000));
        stim_table.push_back(val_row(16'hFFFF));
        stim_table.push_back(val_row(16'h0000));
        stim_table.push_back(val_row(16'h0000));
        stim_table.push_back(val_row(16'h0000));
        stim_table.push_back(val_row(16'h0000));
        stim_table.push_back(val_row(16'h0040));
        stim_table.push_back(val_row(16'h8000));
        // Count lowered below the position mid-request; the next value ends it.
        stim_table.push_back(cfg_row(CFG_VALUE_COUNT, 16'd5));
        stim_table.push_back(val_row(16'h0001));
        stim_table.push_back(val_row(16'h0000));
        stim_table.push_back(val_row(16'h0002));
        stim_table.push_back(cfg_row(CFG_UNIT_ADDRESS, 16'h005A));
        stim_table.push_back(cfg_row(CFG_VALUE_COUNT, 16'd2));
        stim_table.push_back(val_row(16'h0001));
        // Mode switched mid-request: a register word drops the pending coil bits.
        stim_table.push_back(cfg_row(CFG_VALUE_COUNT, 16'd4));
        stim_table.push_back(val_row(16'h0001));
        stim_table.push_back(val_row(16'h0001));
        stim_table.push_back(cfg_row(CFG_COIL_MODE, 16'd0));
        stim_table.push_back(val_row(16'h1234));
        stim_table.push_back(cfg_row(CFG_COIL_MODE, 16'd1));
        stim_table.push_back(val_row(16'h0001));
        // A count above the limit is clamped in the header.
        stim_table.push_back(cfg_row(CFG_COIL_MODE, 16'd0));
        stim_table.push_back(cfg_row(CFG_VALUE_COUNT, 16'd127));
        stim_table.push_back(val_row(16'hA55A));

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CFG) begin
                cfg_write(stim_table[i].idx, stim_table[i].data);
            end else begin
                send_value(stim_table[i].data, stim_table[i].typed,
                           stim_table[i].exp_hi, stim_table[i].exp_lo);
            end
        end

        // Mostly whole requests with random content; some cut short by a new setting.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1) == 1) begin
                cfg_write(CFG_UNIT_ADDRESS, 16'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 1) == 1) begin
                cfg_write(CFG_FIRST_ADDRESS, 16'($urandom_range(0, 65535)));
            end
            if ($urandom_range(0, 1) == 1) begin
                cfg_write(CFG_COIL_MODE, 16'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 1) == 1) begin
                case ($urandom_range(0, 19))
                    0:       cfg_write(CFG_VALUE_COUNT, 16'd123);
                    1:       cfg_write(CFG_VALUE_COUNT, 16'($urandom_range(124, 127)));
                    2:       cfg_write(CFG_VALUE_COUNT, 16'd0);
                    default: cfg_write(CFG_VALUE_COUNT, 16'($urandom_range(1, 12)));
                endcase
            end
            if ($urandom_range(0, 5) == 0) begin
                nvals = $urandom_range(1, 4);
            end else begin
                nvals = active_count() - int'(req_pos);
            end
            if (nvals > RANDOM_ITEMS - random_sent) begin
                nvals = RANDOM_ITEMS - random_sent;
            end
            repeat (nvals) begin
                if (cfg.coil_mode) begin
                    case ($urandom_range(0, 3))
                        0:       v = 16'd0;
                        1:       v = 16'(1 << $urandom_range(0, 15));
                        default: v = 16'($urandom_range(1, 65535));
                    endcase
                end else begin
                    v = 16'($urandom_range(0, 65535));
                end
                send_value(v, 1'b0, 8'd0, 8'd0);
                random_sent++;
            end
        end

        value_ch.valid <= 1'b0;
        while (frame_expect.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!fail_seen) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
